// ===== hdl/gbga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbga_pkg
// Shared types and constants of the GB2312 glyph address parser.
// ----------------------------------------------------------------------------
package gbga_pkg;

  // byte classes
  localparam logic [7:0] HANZI_LO  = 8'hB0;
  localparam logic [7:0] HANZI_HI  = 8'hF7;
  localparam logic [7:0] SYMBOL_LO = 8'hA1;
  localparam logic [7:0] SYMBOL_HI = 8'hA3;
  localparam logic [7:0] TRAIL_LO  = 8'hA1;
  localparam logic [7:0] ASCII_LO  = 8'h20;
  localparam logic [7:0] ASCII_HI  = 8'h7E;
  localparam logic [7:0] TEXT_END  = 8'h00;

  // font ROM layout
  localparam logic [6:0]  ROW_SIZE     = 7'd94;
  localparam logic [12:0] HANZI_BASE   = 13'd846;
  localparam logic [17:0] ASCII_BASE   = 18'h3CF80;

  // column advance
  localparam logic [7:0] WIDE_STEP   = 8'd16;
  localparam logic [7:0] NARROW_STEP = 8'd8;

  // glyph kinds
  localparam logic [1:0] KIND_HANZI  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_ASCII  = 2'd2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
    logic [3:0] start_page;
    logic [7:0] start_column;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic [7:0] lead;
    logic [7:0] text_byte;
    logic [3:0] page;
    logic [7:0] column;
  } glyph_t;

endpackage

// ===== hdl/gb2312_glyph_address_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_glyph_address_parser_core
// Turns a GB2312/ASCII byte stream into font ROM addresses and screen spots.
// ----------------------------------------------------------------------------
// Takes one string byte per cycle while the output is not stalled and returns at
// most one glyph per byte. An accepted byte is held in the input register and
// parsed out of it, and its glyph is loaded into the result register when the
// input register advances (one byte per cycle sustained while not stalled).
// A byte with tuser set starts a new string and loads page and column from
// its tdata. A two-byte character gives its glyph on the trail byte; a zero
// byte ends the string and later bytes are ignored until the next start. The
// rate is set by the single parse stage between the input register and the
// result register; downstream backpressure stalls both.
module gb2312_glyph_address_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] text_byte, [11:8] start_page, [19:12] start_column, [23:20] zero
  input  logic [gbga_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] string_start
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [17:0] font_address, [21:18] glyph_page, [29:22] glyph_column, [31:30] zero
  output logic [gbga_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] glyph_kind
  output logic [1:0]  m_axis_tuser
);

  logic             in_valid;
  gbga_pkg::item_t  in_item;
  logic             advance;
  gbga_pkg::glyph_t glyph;
  logic [17:0]      font_address;
  logic             load;

  assign advance       = in_valid & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;
  assign load          = advance & glyph.hit;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.text_byte    <= s_axis_tdata[7:0];
      in_item.string_start <= s_axis_tuser;
      in_item.start_page   <= s_axis_tdata[11:8];
      in_item.start_column <= s_axis_tdata[19:12];
    end
  end

  gbga_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .glyph   (glyph)
  );

  gbga_addr u_addr (
    .kind         (glyph.kind),
    .lead         (glyph.lead),
    .text_byte    (glyph.text_byte),
    .font_address (font_address)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {2'b00, glyph.column, glyph.page, font_address};
      m_axis_tuser <= glyph.kind;
    end
  end

endmodule

// ===== hdl/gbga_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbga_parser
// String state and byte classification: held lead byte, page/column.
// ----------------------------------------------------------------------------
module gbga_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  gbga_pkg::item_t item,
  output gbga_pkg::glyph_t glyph
);

  logic [7:0] held_lead_byte;
  logic       lead_pending;
  logic       string_active;
  logic [3:0] current_page;
  logic [7:0] current_column;

  logic [7:0] held_lead_byte_next;
  logic       lead_pending_next;
  logic       string_active_next;
  logic [7:0] current_column_next;

  logic       active;
  logic       pending;
  logic [3:0] page;
  logic [7:0] column;
  logic [7:0] b;
  logic       is_lead;
  logic       is_ascii;

  always_comb begin
    b       = item.text_byte;
    active  = item.string_start | string_active;
    pending = ~item.string_start & lead_pending;
    page    = item.string_start ? item.start_page : current_page;
    column  = item.string_start ? item.start_column : current_column;

    is_lead  = ((b >= gbga_pkg::HANZI_LO) && (b <= gbga_pkg::HANZI_HI)) ||
               ((b >= gbga_pkg::SYMBOL_LO) && (b <= gbga_pkg::SYMBOL_HI));
    is_ascii = (b >= gbga_pkg::ASCII_LO) && (b <= gbga_pkg::ASCII_HI);

    glyph.hit       = 1'b0;
    glyph.kind      = gbga_pkg::KIND_ASCII;
    glyph.lead      = held_lead_byte;
    glyph.text_byte = b;
    glyph.page      = page;
    glyph.column    = column;

    held_lead_byte_next = 8'd0;
    lead_pending_next   = 1'b0;
    string_active_next  = active;
    current_column_next = column;

    if (active) begin
      if (pending && (b >= gbga_pkg::TRAIL_LO)) begin
        glyph.hit  = 1'b1;
        glyph.kind = (held_lead_byte >= gbga_pkg::HANZI_LO) ?
                     gbga_pkg::KIND_HANZI : gbga_pkg::KIND_SYMBOL;
        current_column_next = column + gbga_pkg::WIDE_STEP;
      end else if (b == gbga_pkg::TEXT_END) begin
        string_active_next = 1'b0;
      end else if (is_lead) begin
        held_lead_byte_next = b;
        lead_pending_next   = 1'b1;
      end else if (is_ascii) begin
        glyph.hit  = 1'b1;
        current_column_next = column + gbga_pkg::NARROW_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead_byte <= 8'd0;
      lead_pending   <= 1'b0;
      string_active  <= 1'b0;
      current_page   <= 4'd1;
      current_column <= 8'd1;
    end else if (advance) begin
      held_lead_byte <= held_lead_byte_next;
      lead_pending   <= lead_pending_next;
      string_active  <= string_active_next;
      current_page   <= page;
      current_column <= current_column_next;
    end
  end

endmodule

// ===== hdl/gbga_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbga_addr
// Font ROM byte address of a glyph from its kind and character bytes.
// ----------------------------------------------------------------------------
module gbga_addr (
  input  logic [1:0]  kind,
  input  logic [7:0]  lead,
  input  logic [7:0]  text_byte,
  output logic [17:0] font_address
);

  logic [6:0]  row;
  logic [12:0] row_offset;
  logic [12:0] glyph_index;
  logic [6:0]  ascii_index;

  always_comb begin
    // row within the hanzi or symbol area; lead is in range here for those kinds
    row = (kind == gbga_pkg::KIND_HANZI) ? 7'(lead - gbga_pkg::HANZI_LO)
                                         : 7'(lead - gbga_pkg::SYMBOL_LO);
    row_offset = {6'd0, row} * {6'd0, gbga_pkg::ROW_SIZE};
    glyph_index = row_offset + 13'(8'(text_byte - gbga_pkg::TRAIL_LO));
    if (kind == gbga_pkg::KIND_HANZI) begin
      glyph_index = glyph_index + gbga_pkg::HANZI_BASE;
    end
    ascii_index = 7'(text_byte - gbga_pkg::ASCII_LO);

    case (kind)
      gbga_pkg::KIND_ASCII:
        font_address = gbga_pkg::ASCII_BASE + {7'd0, ascii_index, 4'd0};
      default:
        font_address = {glyph_index, 5'd0};
    endcase
  end

endmodule

// ===== verif/gb2312_glyph_address_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb2312_glyph_address_parser_core_tb
// Self-checking bench for the GB2312/ASCII glyph address parser.
// ----------------------------------------------------------------------------
// Feeds string bytes through the slave stream and predicts each glyph
// (font ROM address, kind, page, column) from a parser model kept here.
// Every glyph taken from the master stream is checked field by field against
// the oldest prediction. A directed opener covers byte-class edges, split
// pairs, terminators and restarts. Random strings follow, mixed with noise.
// The sender works in bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module gb2312_glyph_address_parser_core_tb;

  localparam int HANZI_BYTES = 32;
  localparam int ASCII_BYTES = 16;
  localparam int TARGET_REQS = 1550;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [17:0] addr;
    logic [1:0]  kind;
    logic [3:0]  page;
    logic [7:0]  col;
  } glyph_exp_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [gbga_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [gbga_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                      m_axis_tuser;

  gb2312_glyph_address_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gbga_pkg::item_t text_q[$];
  glyph_exp_t      glyph_q[$];
  int              junk_count = 0;
  int              fail_count = 0;

  // parser state of the prediction
  logic [7:0] pred_lead = '0;
  logic       pred_lead_held = 1'b0;
  logic       pred_in_string = 1'b0;
  logic [3:0] pred_page = 4'd1;
  logic [7:0] pred_col = 8'd1;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic add_byte(input logic [7:0] b, input logic st, input logic [3:0] pg,
                          input logic [7:0] col);
    gbga_pkg::item_t req;
    req.text_byte = b;
    req.string_start = st;
    req.start_page = pg;
    req.start_column = col;
    text_q.push_back(req);
  endtask

  task automatic add_cont(input logic [7:0] b);
    add_byte(b, 1'b0, 4'($urandom), 8'($urandom));
  endtask

  task automatic add_random_string();
    logic [7:0] chars[$];
    int         n_chars;
    int         pick;
    logic [3:0] pg;
    logic [7:0] col;
    int         n_junk;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    for (int i = 0; i < n_chars; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        chars.push_back(8'($urandom_range(gbga_pkg::HANZI_LO, gbga_pkg::HANZI_HI)));
        chars.push_back(8'($urandom_range(gbga_pkg::TRAIL_LO, 8'hFF)));
      end else if (pick < 50) begin
        chars.push_back(8'($urandom_range(gbga_pkg::SYMBOL_LO, gbga_pkg::SYMBOL_HI)));
        chars.push_back(8'($urandom_range(gbga_pkg::TRAIL_LO, 8'hFF)));
      end else if (pick < 80) begin
        chars.push_back(8'($urandom_range(gbga_pkg::ASCII_LO, gbga_pkg::ASCII_HI)));
      end else if (pick < 88) begin
        // lead byte followed by something that cannot be a trail
        chars.push_back(($urandom_range(0, 2) == 0)
                        ? 8'($urandom_range(gbga_pkg::SYMBOL_LO, gbga_pkg::SYMBOL_HI))
                        : 8'($urandom_range(gbga_pkg::HANZI_LO, gbga_pkg::HANZI_HI)));
        chars.push_back(8'($urandom_range(8'h01, gbga_pkg::TRAIL_LO - 1)));
      end else begin
        chars.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 99) < 85)
      chars.push_back(gbga_pkg::TEXT_END);
    pg = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    col = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 132));
    add_byte(chars[0], 1'b1, pg, col);
    for (int i = 1; i < chars.size(); i++)
      add_cont(chars[i]);
    if ($urandom_range(0, 9) < 3) begin
      n_junk = $urandom_range(1, 4);
      for (int i = 0; i < n_junk; i++)
        add_cont(8'($urandom_range(0, 255)));
      junk_count += n_junk;
    end
  endtask

  task automatic predict_glyph(input logic [7:0] b, input logic st, input logic [3:0] pg,
                               input logic [7:0] col);
    glyph_exp_t g;
    logic       hit;
    logic [7:0] adv;
    int         lead;
    g = '0;
    hit = 1'b0;
    adv = '0;
    if (st) begin
      pred_page = pg;
      pred_col = col;
      pred_lead = '0;
      pred_lead_held = 1'b0;
      pred_in_string = 1'b1;
    end
    if (!pred_in_string)
      return;
    if (pred_lead_held) begin
      lead = int'(pred_lead);
      pred_lead = '0;
      pred_lead_held = 1'b0;
      if (b >= gbga_pkg::TRAIL_LO) begin
        hit = 1'b1;
        adv = gbga_pkg::WIDE_STEP;
        if (lead >= int'(gbga_pkg::HANZI_LO)) begin
          g.addr = 18'(((lead - int'(gbga_pkg::HANZI_LO)) * int'(gbga_pkg::ROW_SIZE)
                        + (int'(b) - int'(gbga_pkg::TRAIL_LO))
                        + int'(gbga_pkg::HANZI_BASE)) * HANZI_BYTES);
          g.kind = gbga_pkg::KIND_HANZI;
        end else begin
          g.addr = 18'(((lead - int'(gbga_pkg::SYMBOL_LO)) * int'(gbga_pkg::ROW_SIZE)
                        + (int'(b) - int'(gbga_pkg::TRAIL_LO))) * HANZI_BYTES);
          g.kind = gbga_pkg::KIND_SYMBOL;
        end
      end
    end
    // a byte that did not complete a pair is judged on its own
    if (!hit) begin
      if (b == gbga_pkg::TEXT_END) begin
        pred_in_string = 1'b0;
      end else if ((b >= gbga_pkg::HANZI_LO && b <= gbga_pkg::HANZI_HI) ||
                   (b >= gbga_pkg::SYMBOL_LO && b <= gbga_pkg::SYMBOL_HI)) begin
        pred_lead = b;
        pred_lead_held = 1'b1;
      end else if (b >= gbga_pkg::ASCII_LO && b <= gbga_pkg::ASCII_HI) begin
        hit = 1'b1;
        adv = gbga_pkg::NARROW_STEP;
        g.addr = 18'((int'(b) - int'(gbga_pkg::ASCII_LO)) * ASCII_BYTES
                     + int'(gbga_pkg::ASCII_BASE));
        g.kind = gbga_pkg::KIND_ASCII;
      end
    end
    if (hit) begin
      g.page = pred_page;
      g.col = pred_col;
      pred_col = pred_col + adv;
      glyph_q.push_back(g);
    end
  endtask

  // request driver: bursts of random length, random gaps in between
  logic            req_taken = 1'b0;
  gbga_pkg::item_t next_req;
  int              src_gap = 0;
  int              src_burst = 20;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (src_gap > 0) begin
        src_gap = src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() > 0) begin
        next_req = text_q.pop_front();
        s_axis_tdata <= {4'b0, next_req.start_column, next_req.start_page, next_req.text_byte};
        s_axis_tuser <= next_req.string_start;
        s_axis_tvalid <= 1'b1;
        src_burst = src_burst - 1;
        if (src_burst <= 0) begin
          if ($urandom_range(0, 4) == 0) begin
            src_gap = 0;
            src_burst = $urandom_range(50, 200);
          end else begin
            src_gap = $urandom_range(1, 10);
            src_burst = $urandom_range(1, 30);
          end
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // glyph receiver: switches between random stall patterns
  int sink_cycle = 0;
  int sink_mode = 0;
  int sink_hold = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      sink_cycle = sink_cycle + 1;
      if (sink_cycle % 300 == 0)
        sink_mode = $urandom_range(0, 3);
      if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (sink_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (sink_cycle % 5) < 3;
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              sink_hold = $urandom_range(1, 12);
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted glyph
  glyph_exp_t want;
  int         quiet_cycles = 0;

  always @(posedge clk) begin
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_glyph(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[11:8], s_axis_tdata[19:12]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (glyph_q.size() == 0) begin
          $error("unexpected glyph: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = glyph_q.pop_front();
          if (m_axis_tdata[17:0] !== want.addr) begin
            $error("font_address: expected %h, got %h", want.addr, m_axis_tdata[17:0]);
            fail_count++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("glyph_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[21:18] !== want.page) begin
            $error("glyph_page: expected %0d, got %0d", want.page, m_axis_tdata[21:18]);
            fail_count++;
          end
          if (m_axis_tdata[29:22] !== want.col) begin
            $error("glyph_column: expected %0d, got %0d", want.col, m_axis_tdata[29:22]);
            fail_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    // bytes before any string are ignored
    add_byte(8'h41, 1'b0, 4'd3, 8'd7);
    add_byte(8'hB0, 1'b0, 4'd3, 8'd7);
    // ascii edges
    add_byte(8'h41, 1'b1, 4'd1, 8'd1);
    add_cont(gbga_pkg::ASCII_LO);
    add_cont(gbga_pkg::ASCII_HI);
    // hanzi and symbol range corners
    add_cont(gbga_pkg::HANZI_LO); add_cont(gbga_pkg::TRAIL_LO);
    add_cont(gbga_pkg::HANZI_HI); add_cont(8'hFE);
    add_cont(gbga_pkg::HANZI_HI); add_cont(8'hFF);
    add_cont(gbga_pkg::SYMBOL_LO); add_cont(gbga_pkg::TRAIL_LO);
    add_cont(gbga_pkg::SYMBOL_HI); add_cont(8'hFF);
    // lead followed by a lead-range byte still forms a pair
    add_cont(8'hB5); add_cont(8'hB6);
    // lead dropped by a non-trail, which is judged afresh
    add_cont(gbga_pkg::HANZI_LO); add_cont(8'h41);
    add_cont(gbga_pkg::SYMBOL_LO); add_cont(8'hA0);
    // bytes outside every class are skipped
    add_cont(8'h1F); add_cont(8'h7F); add_cont(8'hA4); add_cont(8'hF8);
    // terminator drops a held lead, later bytes ignored
    add_cont(gbga_pkg::HANZI_LO); add_cont(gbga_pkg::TEXT_END);
    add_cont(8'h42); add_cont(gbga_pkg::HANZI_LO); add_cont(gbga_pkg::TRAIL_LO);
    // restart with a lead held, column wraps past 255
    add_byte(gbga_pkg::HANZI_LO, 1'b1, 4'd8, 8'd132);
    add_byte(gbga_pkg::SYMBOL_LO, 1'b1, 4'd15, 8'd255);
    add_cont(8'h41);
    add_cont(gbga_pkg::HANZI_LO); add_cont(gbga_pkg::TRAIL_LO);
    // string that ends on its first byte, then out-of-range start
    add_byte(gbga_pkg::TEXT_END, 1'b1, 4'd2, 8'd9);
    add_byte(8'h7E, 1'b1, 4'd0, 8'd0);
    add_cont(gbga_pkg::TEXT_END);
    junk_count += 2;
    while (text_q.size() - junk_count < TARGET_REQS)
      add_random_string();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (text_q.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    while (glyph_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gbga_pkg.sv
hdl/gbga_parser.sv
hdl/gbga_addr.sv
hdl/gb2312_glyph_address_parser_core.sv
verif/gb2312_glyph_address_parser_core_tb.sv
